>>> rtl/sle_pkg.sv
// Package of the serial line editor: character codes, sizes and the
// operation record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package sle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam int ITEM_MAX = (LINE_CAPACITY - 1 > 5) ? LINE_CAPACITY - 1 : 5;
    localparam int K_W = $clog2(ITEM_MAX + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_BS   = 2'd1,
        K_DONE = 2'd2,
        K_CHAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic             prompt;
        t_kind            kind;
        logic [7:0]       ch;
        logic [CNT_W-1:0] idx;
    } t_op;

endpackage

`default_nettype wire

>>> rtl/sle_front.sv
// Front end of the serial line editor: accepts received bytes, keeps the
// line count and prompt flag, and issues at most one operation per byte.
// Depends on sle_pkg.
`default_nettype none

module sle_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_full,
    output logic             o_ready,
    output logic             o_push,
    output sle_pkg::t_op     o_op
);
    import sle_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_prompt, n_prompt;
    logic             accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_cnt       = r_cnt;
        n_prompt    = r_prompt;
        o_op.prompt = (r_cnt == '0) && r_prompt;
        o_op.ch     = i_byte;
        o_op.idx    = r_cnt;
        o_op.kind   = K_NONE;
        if (i_byte == CH_BS || i_byte == CH_DEL) begin
            if (r_cnt != '0) begin
                o_op.kind = K_BS;
                n_cnt     = r_cnt - 1'b1;
            end
        end else if (i_byte == CH_LF || i_byte == CH_CR ||
                     r_cnt >= CNT_W'(LINE_CAPACITY - 1)) begin
            o_op.kind = K_DONE;
            n_cnt     = '0;
        end else begin
            o_op.kind = K_CHAR;
            n_cnt     = r_cnt + 1'b1;
        end
        if (o_op.prompt) begin
            n_prompt = 1'b0;
        end
        if (o_op.kind == K_DONE) begin
            n_prompt = 1'b1;
        end
        o_push = accept && (o_op.kind != K_NONE || o_op.prompt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_prompt <= 1'b1;
        end else if (accept) begin
            r_cnt    <= n_cnt;
            r_prompt <= n_prompt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LINE_CAPACITY - 1))
        else $error("line count beyond capacity");

endmodule

`default_nettype wire

>>> rtl/sle_queue.sv
// Short operation queue between the front end and the back end.
// Depends on sle_pkg.
`default_nettype none

module sle_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire sle_pkg::t_op i_op,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_empty,
    output sle_pkg::t_op      o_head
);
    import sle_pkg::*;

    t_op           r_ent [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = r_cnt == (QA_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QA_W + 1)'(i_push) - (QA_W + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

>>> rtl/sle_back.sv
// Back end of the serial line editor: holds the line store, carries out
// each operation and sequences its echo and command items into the output.
// Depends on sle_pkg.
`default_nettype none

module sle_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_empty,
    input  wire sle_pkg::t_op i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic              o_echo_valid,
    output logic [7:0]        o_echo_byte,
    output logic              o_cmd_valid,
    output logic [7:0]        o_cmd_byte,
    output logic              o_cmd_end,
    output logic              o_last
);
    import sle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_bstate;

    t_bstate        r_state, n_state;
    t_op            r_op;
    logic [7:0]     r_mem [LINE_CAPACITY];
    logic [7:0]     r_rd;
    logic [K_W-1:0] r_k, n_k;
    logic           r_ov;

    logic [K_W-1:0] base, ne, ncmd, items, j;
    logic           emit;
    logic           it_ev, it_cv, it_ce, it_last;
    logic [7:0]     it_eb;

    always_comb begin
        base  = r_op.prompt ? K_W'(2) : K_W'(0);
        case (r_op.kind)
            K_BS:    ne = base + K_W'(3);
            K_DONE:  ne = base + K_W'(2);
            K_CHAR:  ne = base + K_W'(1);
            default: ne = base;
        endcase
        ncmd    = (r_op.kind == K_DONE) ? K_W'(r_op.idx) : '0;
        items   = (ne > ncmd) ? ne : ncmd;
        j       = r_k - base;
        it_ev   = r_k < ne;
        it_cv   = r_k < ncmd;
        it_ce   = (r_op.kind == K_DONE) &&
                  (r_k == ((ncmd != '0) ? ncmd - 1'b1 : '0));
        it_last = r_k == items - 1'b1;
        it_eb   = '0;
        if (it_ev) begin
            if (r_op.prompt && r_k == K_W'(0)) begin
                it_eb = CH_PROMPT;
            end else if (r_op.prompt && r_k == K_W'(1)) begin
                it_eb = CH_SPACE;
            end else begin
                case (r_op.kind)
                    K_BS:    it_eb = (j == K_W'(1)) ? CH_SPACE : CH_BS;
                    K_DONE:  it_eb = (j == K_W'(0)) ? CH_LF : CH_CR;
                    K_CHAR:  it_eb = r_op.ch;
                    default: it_eb = '0;
                endcase
            end
        end
    end

    always_comb begin
        emit    = (r_state == S_RUN) && (!r_ov || i_ready);
        o_pop   = (r_state == S_IDLE) && !i_empty;
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_RUN;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (emit) begin
                    if (it_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_CHAR) begin
            r_mem[i_head.idx] <= i_head.ch;
        end
        r_rd <= r_mem[n_k[CNT_W-1:0]];
        if (o_pop) begin
            r_op <= i_head;
        end
        if (emit) begin
            o_echo_valid <= it_ev;
            o_echo_byte  <= it_eb;
            o_cmd_valid  <= it_cv;
            o_cmd_byte   <= it_cv ? r_rd : 8'h00;
            o_cmd_end    <= it_ce;
            o_last       <= it_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;

    a_last_ends_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && it_last |=> r_state == S_IDLE)
        else $error("sequencer kept running after the last item");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_k < items)
        else $error("item index ran past the item count");

endmodule

`default_nettype wire

>>> rtl/serial_line_editor_top.sv
// Top level of the serial line editor: front end, operation queue and
// back end. Depends on sle_pkg, sle_front, sle_queue and sle_back.
//
// Received terminal bytes enter on the slave stream (tdata[7:0] = rx_byte),
// one transfer per byte. Each byte yields zero or more result transfers on
// the master stream: tdata holds echo_byte in bits 7:0 and cmd_byte in bits
// 15:8, tuser holds echo_valid, cmd_valid and cmd_end from bit 0 up, and
// tlast marks the final result of the byte. Echo characters cover the
// prompt, backspace erasure, line-end CR/LF and the typed character; when a
// line completes, its stored characters come out on the same transfers.
// The first result of a byte leaves through the queue entry, the back-end
// operation register and the output register; the results of one byte then
// follow at one per cycle while the master side accepts them, and an idle
// sequencer state separates consecutive bytes. A byte yields max(echo
// count, command length) results, the sequencer reading the line store one
// entry per cycle. A four-entry queue lets the input side keep taking bytes
// while results wait. A stall on the master side holds the current result;
// the input side stalls only when the queue is full. Reset empties the
// queue and the line and makes a prompt owed; the line store is not cleared.
`default_nettype none

module serial_line_editor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // echo_byte, cmd_byte
    output logic [2:0]       o_m_axis_tuser,   // echo_valid, cmd_valid, cmd_end
    output logic             o_m_axis_tlast
);
    import sle_pkg::*;

    t_op  front_op, head_op;
    logic push, pop, full, empty;
    logic echo_valid, cmd_valid, cmd_end;
    logic [7:0] echo_byte, cmd_byte;

    sle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_full  (full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_op    (front_op)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_op)
    );

    sle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head_op),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_echo_valid (echo_valid),
        .o_echo_byte  (echo_byte),
        .o_cmd_valid  (cmd_valid),
        .o_cmd_byte   (cmd_byte),
        .o_cmd_end    (cmd_end),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {cmd_byte, echo_byte};
    assign o_m_axis_tuser = {cmd_end, cmd_valid, echo_valid};

endmodule

`default_nettype wire

>>> tb/tb_serial_line_editor_top.sv
// Self-checking testbench of serial_line_editor_top: a directed byte table, then random
// command lines, each byte predicted by a behavioral line editor.
// Depends on sle_pkg and the serial_line_editor_top RTL.
`timescale 1ns / 1ps

module tb_serial_line_editor_top;

    import sle_pkg::*;

    localparam int N_RANDOM     = 310;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        int         n_res;
        logic [7:0] echo0;
    } t_stim_row;

    typedef struct packed {
        logic       echo_v;
        logic [7:0] echo_b;
        logic       cmd_v;
        logic [7:0] cmd_b;
        logic       cmd_end;
        logic       last;
    } t_tx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    t_stim_row   stim_q[$];
    t_stim_row   cur_row;
    t_tx_item    tx_expect_q[$];
    int          next_idx = 0;
    int          rx_accepted = 0;
    int          n_mismatch = 0;
    int          n_results = 0;
    int          n_lines = 0;
    int          n_overflow = 0;
    int          n_erase = 0;

    logic [7:0]  line_buf [LINE_CAPACITY];
    int          line_len = 0;
    bit          prompt_owed = 1'b1;

    serial_line_editor_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic void report_mismatch(string what, t_tx_item want, t_tx_item got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("%0t mismatch (%s): expected ev=%0b eb=%02h cv=%0b cb=%02h end=%0b last=%0b",
                     $realtime, what, want.echo_v, want.echo_b, want.cmd_v, want.cmd_b,
                     want.cmd_end, want.last);
            $display("%0t            actual   ev=%0b eb=%02h cv=%0b cb=%02h end=%0b last=%0b",
                     $realtime, got.echo_v, got.echo_b, got.cmd_v, got.cmd_b,
                     got.cmd_end, got.last);
        end
    endfunction

    // Applies one received byte to the line model and queues the transfers it causes.
    function automatic int predict_line_edit(input logic [7:0] rx, output logic [7:0] echo0);
        logic [7:0] echo [8];
        int         ne = 0;
        int         ncmd = 0;
        int         items;
        bit         done = 1'b0;
        t_tx_item   r;
        echo0 = 8'h00;
        if (line_len == 0 && prompt_owed) begin
            echo[ne++] = CH_PROMPT;
            echo[ne++] = CH_SPACE;
            prompt_owed = 1'b0;
        end
        if (rx == CH_BS || rx == CH_DEL) begin
            if (line_len > 0) begin
                echo[ne++] = CH_BS;
                echo[ne++] = CH_SPACE;
                echo[ne++] = CH_BS;
                line_len--;
                n_erase++;
            end
        end else if (rx == CH_LF || rx == CH_CR || line_len >= LINE_CAPACITY - 1) begin
            if (rx != CH_LF && rx != CH_CR) begin
                n_overflow++;
            end
            echo[ne++] = CH_LF;
            echo[ne++] = CH_CR;
            done = 1'b1;
            ncmd = line_len;
            line_len = 0;
            prompt_owed = 1'b1;
            n_lines++;
        end else begin
            echo[ne++] = rx;
            line_buf[line_len] = rx;
            line_len++;
        end
        items = (ne > ncmd) ? ne : ncmd;
        if (done && items < 1) begin
            items = 1;
        end
        for (int k = 0; k < items; k++) begin
            r.echo_v  = (k < ne);
            r.echo_b  = (k < ne) ? echo[k] : 8'h00;
            r.cmd_v   = (k < ncmd);
            r.cmd_b   = (k < ncmd) ? line_buf[k] : 8'h00;
            r.cmd_end = done && (k == ((ncmd > 0) ? ncmd - 1 : 0));
            r.last    = (k == items - 1);
            tx_expect_q.push_back(r);
        end
        if (ne > 0) begin
            echo0 = echo[0];
        end
        return items;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CH_BS || b == CH_DEL || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic void add_row(logic [7:0] rx, bit typed, int n_res, logic [7:0] echo0);
        t_stim_row row;
        row.rx    = rx;
        row.typed = typed;
        row.n_res = n_res;
        row.echo0 = echo0;
        stim_q.push_back(row);
    endfunction

    function automatic void build_stimulus();
        t_stim_row table_rows [] = '{
            '{CH_BS,   1'b1, 2, CH_PROMPT},
            '{CH_DEL,  1'b1, 0, 8'h00},
            '{CH_CR,   1'b1, 2, CH_LF},
            '{8'h00,   1'b1, 3, CH_PROMPT},
            '{8'hFF,   1'b1, 1, 8'hFF},
            '{8'h80,   1'b1, 1, 8'h80},
            '{CH_DEL,  1'b1, 3, CH_BS},
            '{8'h41,   1'b0, 0, 8'h00},
            '{CH_LF,   1'b1, 3, CH_LF},
            '{CH_LF,   1'b1, 4, CH_PROMPT},
            '{8'h7E,   1'b0, 0, 8'h00},
            '{CH_BS,   1'b0, 0, 8'h00},
            '{CH_DEL,  1'b1, 0, 8'h00},
            '{8'h01,   1'b0, 0, 8'h00},
            '{8'h20,   1'b0, 0, 8'h00},
            '{8'h5A,   1'b0, 0, 8'h00},
            '{CH_CR,   1'b0, 0, 8'h00}
        };
        int n_rand = 0;
        int len;
        bit full_line;
        foreach (table_rows[i]) begin
            stim_q.push_back(table_rows[i]);
        end
        // Mostly well-formed lines with edits; some lines run into the capacity limit.
        while (n_rand < N_RANDOM) begin
            full_line = (n_rand == 0) || ($urandom_range(9) == 0);
            len = full_line ? LINE_CAPACITY - 1 : $urandom_range(12);
            for (int c = 0; c < len; c++) begin
                if (!full_line && $urandom_range(99) < 15) begin
                    add_row($urandom_range(1) ? CH_BS : CH_DEL, 1'b0, 0, 8'h00);
                    n_rand++;
                end
                if ($urandom_range(99) < 5) begin
                    add_row(8'($urandom_range(255)), 1'b0, 0, 8'h00);
                    n_rand++;
                end
                add_row(text_byte(), 1'b0, 0, 8'h00);
                n_rand++;
            end
            if (full_line) begin
                add_row($urandom_range(2) == 0 ? CH_CR : text_byte(), 1'b0, 0, 8'h00);
            end else begin
                add_row($urandom_range(1) ? CH_CR : CH_LF, 1'b0, 0, 8'h00);
            end
            n_rand++;
        end
    endfunction

    function automatic int idle_phase();
        return (stim_q.size() == 0) ? 0 : (next_idx * 4) / stim_q.size();
    endfunction

    function automatic int rx_idle_pct();
        int pct [4] = '{0, 68, 0, 24};
        return pct[idle_phase() > 3 ? 3 : idle_phase()];
    endfunction

    function automatic int tx_stall_pct();
        int pct [4] = '{0, 0, 68, 24};
        return pct[idle_phase() > 3 ? 3 : idle_phase()];
    endfunction

    always @(posedge i_clk) begin
        int         n;
        logic [7:0] e0;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                rx_accepted++;
                n = predict_line_edit(s_tdata, e0);
                if (cur_row.typed && (n != cur_row.n_res ||
                                      (n > 0 && e0 != cur_row.echo0))) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("%0t table row %0d (byte %02h): expected %0d results, echo %02h",
                                 $realtime, rx_accepted, s_tdata, cur_row.n_res, cur_row.echo0);
                        $display("%0t            predicted %0d results, echo %02h",
                                 $realtime, n, e0);
                    end
                end
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (next_idx < stim_q.size() && $urandom_range(99) >= rx_idle_pct()) begin
                    cur_row = stim_q[next_idx];
                    next_idx++;
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_row.rx;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_tx_item got;
        t_tx_item want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.echo_v  = o_m_axis_tuser[0];
            got.echo_b  = o_m_axis_tdata[7:0];
            got.cmd_v   = o_m_axis_tuser[1];
            got.cmd_b   = o_m_axis_tdata[15:8];
            got.cmd_end = o_m_axis_tuser[2];
            got.last    = o_m_axis_tlast;
            n_results++;
            if (tx_expect_q.size() == 0) begin
                report_mismatch("no transfer expected", '0, got);
            end else begin
                want = tx_expect_q.pop_front();
                if (got !== want) begin
                    report_mismatch("field", want, got);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= tx_stall_pct());
    end

    initial begin
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (rx_accepted < stim_q.size() || tx_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tx_expect_q.size() != 0) begin
            report_mismatch("transfer never arrived", tx_expect_q[0], '0);
        end
        $display("Sent %0d bytes and checked %0d output transfers.",
                 rx_accepted, n_results);
        $display("Covered %0d completed lines (%0d ended at capacity), %0d erasures.",
                 n_lines, n_overflow, n_erase);
        if (n_mismatch == 0) begin
            $display("[serial_line_editor_top] OK");
        end else begin
            $display("[serial_line_editor_top] ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d bytes sent and %0d transfers pending.",
                 rx_accepted, tx_expect_q.size());
        $display("[serial_line_editor_top] ERROR");
        $finish;
    end

endmodule
